// ----- sv/u8u16_pkg.sv -----
// Package for the UTF-8 to UTF-16LE transcoder: types, byte-class constants
// and UTF-16 constants. No dependencies.
package u8u16_pkg;

   localparam int MAX_RESULTS = 4;

   localparam logic [15:0] CAP_RESET  = 16'hFFFF;
   localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
   localparam logic [15:0] SURR_HIGH  = 16'hD800;
   localparam logic [15:0] SURR_LOW   = 16'hDC00;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;

   // byte classes: (b & MASK) == TAG
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;

   // open multi-byte sequence
   typedef struct packed {
      logic [7:0]  lead;   // zero when no sequence is open
      logic [1:0]  conts;
      logic [1:0]  need;
      logic [20:0] acc;
   } seq_type;

   // everything one input byte produces
   typedef struct packed {
      logic [MAX_RESULTS-1:0][15:0] units;
      logic [2:0]                   n_units;
      logic                         has_end;
      logic [15:0]                  end_total;
      logic                         end_ovf;
   } result_set_type;

endpackage

// ----- sv/utf8_to_utf16le_transcoder_unit.sv -----
// Top level of the UTF-8 to UTF-16LE transcoder: input register, string state,
// decoder and result buffer. Depends on u8u16_pkg, u8u16_decoder, u8u16_result_buffer.
// req: one UTF-8 byte per transfer; a zero byte closes the string.
// rsp: one UTF-16 code unit or one end item per transfer. tuser[0] marks a unit,
//   tuser[1] the end item; tlast marks the last result caused by one byte. The end
//   item carries the output byte total, or zero with the overflow bit set when the
//   string ran past the capacity.
// csr: csr_wr_en writes csr_wr_data into the output capacity (bytes); write it
//   only while no string bytes are in flight.
// Path: a byte accepted into the input register is decoded into the result register
//   once that register can load; its first result then transfers from there.
// Throughput: one byte per cycle while each byte gives at most one result and
//   rsp_tready is high. A byte with n results (broken sequence, surrogate pair) holds
//   the result register for n rsp transfers; a byte with no result leaves it empty.
// Reset: synchronous; clears the open sequence, byte count and overflow flag and
//   sets the capacity to 65535. The string state also clears when a zero byte moves
//   into the result register; the capacity keeps its value.
// Stall: while rsp_tready is low the result register holds, the input register
//   takes a byte if it is empty, then req_tready drops.
module utf8_to_utf16le_transcoder_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] data_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [15:0] code_unit, [31:16] total_bytes, [32] overflow, [39:33] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // rsp_tuser: [0] unit_valid, [1] end_of_string
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // string state, committed when a byte moves into the result register
   u8u16_pkg::seq_type seq_ff, seq_in;
   logic [15:0]        count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [15:0]        cap_ff;

   u8u16_pkg::result_set_type dec_set;
   logic load_ready;
   logic commit;
   logic req_xfer;

   assign commit     = in_valid_ff && load_ready;
   assign req_tready = !in_valid_ff || commit;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (commit) begin
         in_valid_in = 1'b0;
      end
   end

   u8u16_decoder u_decoder (
      .data_byte       (in_byte_ff),
      .seq             (seq_ff),
      .byte_count      (count_ff),
      .overflowed      (ovf_ff),
      .capacity        (cap_ff),
      .seq_next        (seq_in),
      .byte_count_next (count_in),
      .overflowed_next (ovf_in),
      .results         (dec_set)
   );

   u8u16_result_buffer u_result_buffer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load_set   (dec_set),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         seq_ff      <= '0;
         count_ff    <= 16'd0;
         ovf_ff      <= 1'b0;
         cap_ff      <= u8u16_pkg::CAP_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (commit) begin
            seq_ff   <= seq_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
      end
   end

   // output bytes come in whole units, so the count stays even
   a_count_even: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] == 1'b0)
      else $error("odd output byte count");

   // a zero byte closes the string and clears its state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      commit && (in_byte_ff == 8'd0) |=> (count_ff == 16'd0) && !ovf_ff && (seq_ff.lead == 8'd0))
      else $error("string state not cleared after end of string");

   // the end item is always the last result of its byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("end item not last of run");

   // the overflow bit only appears on an end item
   a_ovf_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tuser[1] && (rsp_tdata[31:16] == 16'd0))
      else $error("overflow flag outside end item");

   // an empty input register always takes a byte
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input register empty but not ready");

endmodule

// ----- sv/u8u16_decoder.sv -----
// Combinational decode of one UTF-8 byte against the open-sequence state.
// Produces the result set and the next state. Depends on u8u16_pkg.
module u8u16_decoder (
   input  logic [7:0]                  data_byte,
   input  u8u16_pkg::seq_type          seq,
   input  logic [15:0]                 byte_count,
   input  logic                        overflowed,
   input  logic [15:0]                 capacity,
   output u8u16_pkg::seq_type          seq_next,
   output logic [15:0]                 byte_count_next,
   output logic                        overflowed_next,
   output u8u16_pkg::result_set_type   results
);

   logic        is_open;
   logic        is_cont;
   logic [20:0] acc_cat;
   logic [1:0]  conts_inc;
   logic        seq_done;
   logic        cp_big;
   logic [20:0] cp_off;
   logic        fit_cp;
   logic [3:0]  fit;
   logic [2:0]  e_broken;
   logic [2:0]  e_total;
   logic        fresh_emit;
   logic [15:0] fresh_unit;
   logic [2:0]  n_fit;
   logic        ovf_mid;
   logic [15:0] count_mid;

   assign is_open   = (seq.lead != 8'd0);
   assign is_cont   = ((data_byte & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG);
   assign acc_cat   = {seq.acc[14:0], data_byte[5:0]};
   assign conts_inc = seq.conts + 2'd1;
   assign seq_done  = (conts_inc >= seq.need);
   assign cp_big    = |acc_cat[20:16];
   assign cp_off    = acc_cat - u8u16_pkg::SUPP_BASE;
   assign fit_cp    = ({1'b0, byte_count} + (cp_big ? 17'd4 : 17'd2)) <= {1'b0, capacity};

   // every unit on the broken / fresh path costs two bytes
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         fit[j] = ({1'b0, byte_count} + 17'(2 * (j + 1))) <= {1'b0, capacity};
      end
   end

   assign e_broken = is_open ? (3'd1 + {1'b0, seq.conts}) : 3'd0;

   always_comb begin
      fresh_emit = 1'b0;
      fresh_unit = u8u16_pkg::REPL_UNIT;
      if (data_byte == 8'd0) begin
         fresh_emit = 1'b0;
      end else if (data_byte[7] == 1'b0) begin
         fresh_emit = 1'b1;
         fresh_unit = {8'd0, data_byte};
      end else if (((data_byte & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) ||
                   ((data_byte & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) ||
                   ((data_byte & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG)) begin
         fresh_emit = 1'b0;
      end else begin
         fresh_emit = 1'b1;
      end
   end

   assign e_total = e_broken + {2'd0, fresh_emit};

   always_comb begin
      n_fit = 3'd0;
      for (int j = 0; j < 4; j++) begin
         if ((3'(j) < e_total) && fit[j] && !overflowed) begin
            n_fit = n_fit + 3'd1;
         end
      end
   end

   assign ovf_mid   = overflowed || (n_fit < e_total);
   assign count_mid = byte_count + {12'd0, n_fit, 1'b0};

   always_comb begin
      seq_next        = '0;
      byte_count_next = byte_count;
      overflowed_next = overflowed;
      results         = '0;
      if (is_open && is_cont) begin
         // continuation byte of an open sequence
         if (seq_done) begin
            if (!overflowed && fit_cp) begin
               byte_count_next = byte_count + (cp_big ? 16'd4 : 16'd2);
               if (cp_big) begin
                  results.units[0] = u8u16_pkg::SURR_HIGH | {5'd0, cp_off[20:10]};
                  results.units[1] = u8u16_pkg::SURR_LOW | {6'd0, cp_off[9:0]};
                  results.n_units  = 3'd2;
               end else begin
                  results.units[0] = acc_cat[15:0];
                  results.n_units  = 3'd1;
               end
            end else begin
               overflowed_next = 1'b1;
            end
         end else begin
            seq_next.lead  = seq.lead;
            seq_next.conts = conts_inc;
            seq_next.need  = seq.need;
            seq_next.acc   = acc_cat;
         end
      end else begin
         // replacements for a broken sequence, then the byte itself
         for (int j = 0; j < u8u16_pkg::MAX_RESULTS; j++) begin
            results.units[j] = (3'(j) < e_broken) ? u8u16_pkg::REPL_UNIT : fresh_unit;
         end
         results.n_units = n_fit;
         byte_count_next = count_mid;
         overflowed_next = ovf_mid;
         if (data_byte == 8'd0) begin
            results.has_end   = 1'b1;
            results.end_total = ovf_mid ? 16'd0 : count_mid;
            results.end_ovf   = ovf_mid;
            byte_count_next   = 16'd0;
            overflowed_next   = 1'b0;
         end else if ((data_byte & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
            seq_next.lead = data_byte;
            seq_next.need = 2'd1;
            seq_next.acc  = {16'd0, data_byte[4:0]};
         end else if ((data_byte & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
            seq_next.lead = data_byte;
            seq_next.need = 2'd2;
            seq_next.acc  = {17'd0, data_byte[3:0]};
         end else if ((data_byte & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG) begin
            seq_next.lead = data_byte;
            seq_next.need = 2'd3;
            seq_next.acc  = {18'd0, data_byte[2:0]};
         end
      end
   end

endmodule

// ----- sv/u8u16_result_buffer.sv -----
// Result register: holds the result set of one byte and hands it out one
// transfer at a time on the rsp channel. Depends on u8u16_pkg.
module u8u16_result_buffer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load_valid,
   input  u8u16_pkg::result_set_type   load_set,
   output logic                        load_ready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   u8u16_pkg::result_set_type set_ff;
   logic [2:0] rem_ff, rem_in;
   logic [1:0] idx_ff, idx_in;
   logic       is_end;
   logic       xfer;
   logic       load;

   assign rsp_tvalid = (rem_ff != 3'd0);
   assign xfer       = rsp_tvalid && rsp_tready;
   assign load_ready = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_tready);
   assign load       = load_valid && load_ready;

   // the end item, when present, is always the last of the set
   assign is_end    = set_ff.has_end && (rem_ff == 3'd1);
   assign rsp_tlast = (rem_ff == 3'd1);
   assign rsp_tuser = {is_end, !is_end};
   assign rsp_tdata = {7'd0,
                       is_end && set_ff.end_ovf,
                       is_end ? set_ff.end_total : 16'd0,
                       is_end ? 16'd0 : set_ff.units[idx_ff]};

   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load) begin
         rem_in = load_set.n_units + {2'd0, load_set.has_end};
         idx_in = 2'd0;
      end else if (xfer) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         set_ff <= load_set;
      end
   end

endmodule

// ----- verif/utf8_to_utf16le_transcoder_unit_tb.sv -----
// Self-checking testbench for utf8_to_utf16le_transcoder_unit: directed byte table, then
// random UTF-8 text under several capacities and handshake pacing.
// Depends on u8u16_pkg and the transcoder RTL.
module utf8_to_utf16le_transcoder_unit_tb;

   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either channel
   localparam int SETTLE_CYCLES  = 6;     // covers bytes still in the input and result registers
   localparam int MAX_REPORTS    = 10;
   localparam int N_DIRECTED     = 25;

   // One rsp transfer, split into its fields.
   typedef struct packed {
      logic        last;
      logic        eos;
      logic        unit_valid;
      logic [6:0]  pad;
      logic        ovf;
      logic [15:0] total;
      logic [15:0] unit;
   } utf16_item_type;

   // Directed row: byte to send, and a hand-written single result where it is obvious.
   typedef struct packed {
      logic [7:0]  data;
      logic        typed;
      logic        is_end;
      logic [15:0] unit;
   } text_row_type;

   typedef struct packed {
      logic           typed;
      utf16_item_type want;
   } byte_note_type;

   localparam text_row_type DIRECTED_TEXT [N_DIRECTED] = '{
      '{8'h00, 1'b1, 1'b1, 16'h0000},  // empty string right after reset
      '{8'h41, 1'b1, 1'b0, 16'h0041},
      '{8'h7F, 1'b1, 1'b0, 16'h007F},  // top of ASCII
      '{8'hC3, 1'b0, 1'b0, 16'h0000},  // two-byte sequence
      '{8'hA9, 1'b0, 1'b0, 16'h0000},
      '{8'hE2, 1'b0, 1'b0, 16'h0000},  // three-byte sequence
      '{8'h82, 1'b0, 1'b0, 16'h0000},
      '{8'hAC, 1'b0, 1'b0, 16'h0000},
      '{8'hF0, 1'b0, 1'b0, 16'h0000},  // four-byte, surrogate pair
      '{8'h9F, 1'b0, 1'b0, 16'h0000},
      '{8'h98, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b0, 1'b0, 16'h0000},
      '{8'hF7, 1'b0, 1'b0, 16'h0000},  // largest four-byte value, out of range
      '{8'hBF, 1'b0, 1'b0, 16'h0000},
      '{8'hBF, 1'b0, 1'b0, 16'h0000},
      '{8'hBF, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b1, 1'b0, u8u16_pkg::REPL_UNIT},  // stray continuation
      '{8'hFF, 1'b1, 1'b0, u8u16_pkg::REPL_UNIT},  // invalid byte
      '{8'hF8, 1'b1, 1'b0, u8u16_pkg::REPL_UNIT},  // lowest invalid lead
      '{8'hF0, 1'b0, 1'b0, 16'h0000},  // broken four-byte: three replacements + 'A'
      '{8'h80, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b0, 1'b0, 16'h0000},
      '{8'h41, 1'b0, 1'b0, 16'h0000},
      '{8'hC3, 1'b0, 1'b0, 16'h0000},  // open lead cut by the terminator
      '{8'h00, 1'b0, 1'b0, 16'h0000}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   // Predictor state: capacity register and per-string decode state.
   logic [15:0] capacity;
   logic [7:0]  seq_lead;
   logic [1:0]  seq_have;
   logic [1:0]  seq_need;
   logic [20:0] seq_acc;
   logic [15:0] out_bytes;
   logic        str_ovf;

   utf16_item_type step_items[$];      // results of the byte being decoded
   utf16_item_type utf16_expected[$];  // results still owed by the block
   byte_note_type  byte_notes[$];      // one per byte driven, in order

   int fault_count;
   int idle_cycles;
   int bytes_sent;
   int send_idle_pct;
   int recv_stall_pct;

   utf8_to_utf16le_transcoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic utf16_item_type unit_item(input logic [15:0] u);
      utf16_item_type it;
      it = '0;
      it.unit = u;
      it.unit_valid = 1'b1;
      return it;
   endfunction

   function automatic utf16_item_type end_item(input logic [15:0] total, input logic ovf);
      utf16_item_type it;
      it = '0;
      it.total = total;
      it.ovf = ovf;
      it.eos = 1'b1;
      return it;
   endfunction

   function void drop_sequence();
      seq_lead = '0;
      seq_have = '0;
      seq_need = '0;
      seq_acc  = '0;
   endfunction

   // Capacity check covers a surrogate pair as a whole; overflow is sticky per string.
   function void emit_code_point(input logic [20:0] cp);
      int          need;
      logic [20:0] off;
      need = (cp >= u8u16_pkg::SUPP_BASE) ? 4 : 2;
      if (!str_ovf) begin
         if (int'(out_bytes) + need > int'(capacity)) begin
            str_ovf = 1'b1;
         end else begin
            out_bytes = out_bytes + 16'(need);
            if (need == 4) begin
               off = cp - u8u16_pkg::SUPP_BASE;
               // high half is a plain OR: out-of-range values bleed into the tag bits
               step_items.push_back(unit_item(u8u16_pkg::SURR_HIGH | 16'(off >> 10)));
               step_items.push_back(unit_item(u8u16_pkg::SURR_LOW | {6'd0, off[9:0]}));
            end else begin
               step_items.push_back(unit_item(cp[15:0]));
            end
         end
      end
   endfunction

   // Decodes one accepted byte into step_items and marks the last of them.
   function void transcode_byte(input logic [7:0] b);
      logic [20:0]    cp;
      utf16_item_type tail;
      step_items.delete();
      if (seq_lead != 8'd0 && (b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG) begin
         seq_acc  = {seq_acc[14:0], b[5:0]};
         seq_have = seq_have + 2'd1;
         if (seq_have >= seq_need) begin
            cp = seq_acc;
            drop_sequence();
            emit_code_point(cp);
         end
      end else begin
         // broken sequence: one replacement for the lead, one per buffered continuation
         if (seq_lead != 8'd0) begin
            emit_code_point(21'(u8u16_pkg::REPL_UNIT));
            for (int k = 0; k < int'(seq_have); k++)
               emit_code_point(21'(u8u16_pkg::REPL_UNIT));
            drop_sequence();
         end
         if (b == 8'd0) begin
            step_items.push_back(end_item(str_ovf ? 16'd0 : out_bytes, str_ovf));
            drop_sequence();
            out_bytes = '0;
            str_ovf   = 1'b0;
         end else if (b < 8'h80) begin
            emit_code_point(21'(b));
         end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_TAG) begin
            seq_lead = b;
            seq_need = 2'd1;
            seq_acc  = 21'(b[4:0]);
         end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_TAG) begin
            seq_lead = b;
            seq_need = 2'd2;
            seq_acc  = 21'(b[3:0]);
         end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_TAG) begin
            seq_lead = b;
            seq_need = 2'd3;
            seq_acc  = 21'(b[2:0]);
         end else begin
            emit_code_point(21'(u8u16_pkg::REPL_UNIT));
         end
      end
      if (step_items.size() > 0) begin
         tail = step_items.pop_back();
         tail.last = 1'b1;
         step_items.push_back(tail);
      end
   endfunction

   // Monitor: predicts on every req transfer, checks every rsp transfer, paces rsp_tready.
   always @(posedge clock) begin : monitor
      byte_note_type  note;
      utf16_item_type got;
      utf16_item_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            transcode_byte(req_tdata);
            note = (byte_notes.size() > 0) ? byte_notes.pop_front() : '0;
            if (note.typed)
               utf16_expected.push_back(note.want);
            else
               foreach (step_items[i]) utf16_expected.push_back(step_items[i]);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.unit       = rsp_tdata[15:0];
            got.total      = rsp_tdata[31:16];
            got.ovf        = rsp_tdata[32];
            got.pad        = rsp_tdata[39:33];
            got.unit_valid = rsp_tuser[0];
            got.eos        = rsp_tuser[1];
            got.last       = rsp_tlast;
            if (utf16_expected.size() == 0) begin
               if (fault_count < MAX_REPORTS)
                  $display("unexpected result: unit %h total %h ovf %b valid %b eos %b last %b",
                           got.unit, got.total, got.ovf, got.unit_valid, got.eos, got.last);
               fault_count++;
            end else begin
               want = utf16_expected.pop_front();
               if (got !== want) begin
                  if (fault_count < MAX_REPORTS) begin
                     $write("mismatch exp/act: unit %h/%h total %h/%h ovf %b/%b ",
                            want.unit, got.unit, want.total, got.total, want.ovf, got.ovf);
                     $display("valid %b/%b eos %b/%b last %b/%b pad %h/%h",
                              want.unit_valid, got.unit_valid, want.eos, got.eos,
                              want.last, got.last, want.pad, got.pad);
                  end
                  fault_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL utf8_to_utf16le_transcoder_unit");
            $finish;
         end
      end
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // One req transfer; valid stays up into the next byte unless the sender idles.
   task automatic drive_byte(input logic [7:0] b, input logic typed,
                             input utf16_item_type want);
      byte_note_type note;
      note.typed = typed;
      note.want  = want;
      byte_notes.push_back(note);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic drive_any(input logic [7:0] b);
      drive_byte(b, 1'b0, '0);
   endtask

   task automatic await_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (utf16_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] v);
      await_drain();
      // bytes that give no result may still sit in the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity = v;
   endtask

   // Lead of an n-continuation sequence followed by `sent` random continuations.
   task automatic send_sequence(input int n, input int sent);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = (n == 1) ? 8'hC0 : (n == 2) ? 8'hE0 : 8'hF0;
      hi = (n == 1) ? 8'hDF : (n == 2) ? 8'hEF : 8'hF7;
      drive_any(8'($urandom_range(hi, lo)));
      repeat (sent) drive_any(8'($urandom_range(8'hBF, 8'h80)));
   endtask

   // Mostly well-formed strings; some truncated sequences and raw noise bytes.
   task automatic send_random_text(input int budget);
      int stop;
      int pick;
      int n;
      bit first;
      stop  = bytes_sent + budget;
      first = 1'b1;
      while (bytes_sent < stop) begin
         repeat ($urandom_range(9, 0)) begin
            pick = $urandom_range(99, 0);
            if (pick < 25) begin
               drive_any(8'($urandom_range(8'h7F, 8'h01)));
            end else if (pick < 45) begin
               send_sequence(1, 1);
            end else if (pick < 65) begin
               send_sequence(2, 2);
            end else if (pick < 80) begin
               send_sequence(3, 3);
            end else if (pick < 90) begin
               n = $urandom_range(3, 1);
               send_sequence(n, $urandom_range(n - 1, 0));
            end else begin
               drive_any(8'($urandom_range(255, 0)));
            end
         end
         // some strings run on into the next phase, across a capacity change
         if ($urandom_range(99, 0) < 85) begin
            drive_any(8'h00);
            if (first || $urandom_range(7, 0) == 0) await_drain();
            first = 1'b0;
         end
      end
   endtask

   task automatic run_phase(input logic [15:0] cap, input int sidle, input int rstall,
                            input int budget);
      write_capacity(cap);
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      send_random_text(budget);
   endtask

   initial begin
      utf16_item_type want;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      capacity    = u8u16_pkg::CAP_RESET;
      out_bytes   = '0;
      str_ovf     = 1'b0;
      drop_sequence();
      fault_count    = 0;
      idle_cycles    = 0;
      bytes_sent     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table, reset capacity, no idling
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (DIRECTED_TEXT[i].is_end)
            want = end_item(16'd0, 1'b0);
         else
            want = unit_item(DIRECTED_TEXT[i].unit);
         want.last = 1'b1;
         drive_byte(DIRECTED_TEXT[i].data, DIRECTED_TEXT[i].typed, want);
      end

      // capacity extremes and small values, with each pacing mix
      run_phase(16'd0, 81, 0, 30);
      run_phase(16'($urandom_range(40, 2)), 0, 81, 80);
      run_phase(16'hFFFF, 29, 29, 90);
      run_phase(16'd1, 0, 0, 40);
      run_phase(16'($urandom_range(200, 41)), 81, 0, 60);
      run_phase(16'hFFFE, 0, 0, 55);

      await_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && utf16_expected.size() == 0)
         $display("PASS utf8_to_utf16le_transcoder_unit");
      else
         $display("FAIL utf8_to_utf16le_transcoder_unit");
      $finish;
   end

endmodule
